>>> rtl/pid_pls_pkg.sv
// Shared types, constants and register codes for the position PID loop.
package pid_pls_pkg;

  localparam int INTEGRAL_WIDTH = 48;
  localparam int TARGET_SCALE   = 7586;

  localparam int GAIN_WIDTH     = 16;
  localparam int POS_WIDTH      = 32;
  localparam int DRIVE_WIDTH    = 24;
  localparam int DBAND_WIDTH    = 16;
  localparam int TICKS_WIDTH    = 4;
  localparam int LIMIT_WIDTH    = 23;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 23;

  localparam int SCALE_WIDTH  = $clog2(TARGET_SCALE + 1) + 1;
  localparam int PROD_P_WIDTH = GAIN_WIDTH + POS_WIDTH;
  localparam int PROD_D_WIDTH = GAIN_WIDTH + POS_WIDTH + 1;
  localparam int PROD_I_WIDTH = GAIN_WIDTH + INTEGRAL_WIDTH;
  localparam int SUM_WIDTH    = PROD_I_WIDTH + 2;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_GAIN_P       = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_GAIN_I       = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_GAIN_D       = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEADBAND     = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SETTLE_TICKS = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DRIVE_LIMIT  = 3'd5;

  localparam logic [1:0] CMD_HOLD  = 2'd0;
  localparam logic [1:0] CMD_DRIVE = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  localparam logic signed [GAIN_WIDTH-1:0]  RST_GAIN_P       = 16'sd512;
  localparam logic signed [GAIN_WIDTH-1:0]  RST_GAIN_I       = 16'sd0;
  localparam logic signed [GAIN_WIDTH-1:0]  RST_GAIN_D       = 16'sd0;
  localparam logic [DBAND_WIDTH-1:0]        RST_DEADBAND     = 16'd655;
  localparam logic [TICKS_WIDTH-1:0]        RST_SETTLE_TICKS = 4'd5;
  localparam logic [LIMIT_WIDTH-1:0]        RST_DRIVE_LIMIT  = 23'd786432;

  typedef struct packed {
    logic signed [GAIN_WIDTH-1:0] gain_p;
    logic signed [GAIN_WIDTH-1:0] gain_i;
    logic signed [GAIN_WIDTH-1:0] gain_d;
    logic [DBAND_WIDTH-1:0]       deadband;
    logic [TICKS_WIDTH-1:0]       settle_ticks;
    logic [LIMIT_WIDTH-1:0]       drive_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                    motor_command;
    logic signed [DRIVE_WIDTH-1:0] drive_value;
    logic                          move_finished;
    logic                          reset_sensors;
  } res_t;

endpackage

>>> rtl/pid_position_loop_with_settle.sv
// Top level of the position PID loop: handshake stages and register file.
//
//   Channel | Direction | Handshake            | Payload
//   input   | in        | in_valid_i/in_stall_o   | opcode, encoder_raw, target_distance
//   output  | out       | out_valid_o/out_stall_i | motor_command, drive_value,
//           |           |                         | move_finished, reset_sensors
//   config  | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One transaction is accepted per cycle unless the input is stalled; its result is held in the output register.
// The whole loop update is one pass between the input register and the output register.
// Reset clears the loop state and loads the default register values at once.
// A stall on the output holds the result, and the input is stalled only when
// the input register is full and cannot move into the output register.
module pid_position_loop_with_settle
  import pid_pls_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic signed [POS_WIDTH-1:0]   encoder_raw_i,
  input  logic signed [POS_WIDTH-1:0]   target_distance_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    motor_command_o,
  output logic signed [DRIVE_WIDTH-1:0] drive_value_o,
  output logic                          move_finished_o,
  output logic                          reset_sensors_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]      cfg_index_i,
  input  logic [CFG_DATA_WIDTH-1:0]     cfg_data_i
);

  cfg_t                        cfg_q, cfg_d;
  logic                        in_valid_q, in_valid_d;
  logic                        opcode_q;
  logic signed [POS_WIDTH-1:0] encoder_q;
  logic signed [POS_WIDTH-1:0] distance_q;
  logic                        out_valid_q, out_valid_d;
  res_t                        res_q;
  res_t                        res;
  logic                        step;
  logic                        in_take;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GAIN_P:       cfg_d.gain_p       = $signed(cfg_data_i[GAIN_WIDTH-1:0]);
        CFG_GAIN_I:       cfg_d.gain_i       = $signed(cfg_data_i[GAIN_WIDTH-1:0]);
        CFG_GAIN_D:       cfg_d.gain_d       = $signed(cfg_data_i[GAIN_WIDTH-1:0]);
        CFG_DEADBAND:     cfg_d.deadband     = cfg_data_i[DBAND_WIDTH-1:0];
        CFG_SETTLE_TICKS: cfg_d.settle_ticks = cfg_data_i[TICKS_WIDTH-1:0];
        CFG_DRIVE_LIMIT:  cfg_d.drive_limit  = cfg_data_i[LIMIT_WIDTH-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p       <= RST_GAIN_P;
      cfg_q.gain_i       <= RST_GAIN_I;
      cfg_q.gain_d       <= RST_GAIN_D;
      cfg_q.deadband     <= RST_DEADBAND;
      cfg_q.settle_ticks <= RST_SETTLE_TICKS;
      cfg_q.drive_limit  <= RST_DRIVE_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d  = in_take || (in_valid_q && !step);
    out_valid_d = step || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      opcode_q   <= opcode_i;
      encoder_q  <= encoder_raw_i;
      distance_q <= target_distance_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  pid_pls_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .opcode_i          (opcode_q),
    .encoder_raw_i     (encoder_q),
    .target_distance_i (distance_q),
    .cfg_i             (cfg_q),
    .res_o             (res)
  );

  assign out_valid_o     = out_valid_q;
  assign motor_command_o = res_q.motor_command;
  assign drive_value_o   = res_q.drive_value;
  assign move_finished_o = res_q.move_finished;
  assign reset_sensors_o = res_q.reset_sensors;

endmodule

>>> rtl/pid_pls_core.sv
// Loop state and combinational PID, deadband and settle computation.
module pid_pls_core
  import pid_pls_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          opcode_i,
  input  logic signed [POS_WIDTH-1:0]   encoder_raw_i,
  input  logic signed [POS_WIDTH-1:0]   target_distance_i,
  input  cfg_t                          cfg_i,
  output res_t                          res_o
);

  localparam logic signed [SCALE_WIDTH-1:0] SCALE_S = SCALE_WIDTH'(TARGET_SCALE);
  localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
  localparam logic signed [INTEGRAL_WIDTH-1:0] INT_MAX =
    {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
  localparam logic signed [INTEGRAL_WIDTH-1:0] INT_MIN =
    {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

  logic signed [POS_WIDTH-1:0]      target_q, target_d;
  logic signed [POS_WIDTH-1:0]      prev_err_q, prev_err_d;
  logic signed [INTEGRAL_WIDTH-1:0] err_sum_q, err_sum_d;
  logic [TICKS_WIDTH-1:0]           settle_cnt_q, settle_cnt_d;
  logic                             finished_q, finished_d;

  logic signed [POS_WIDTH+SCALE_WIDTH-1:0] tgt_prod;
  logic signed [POS_WIDTH+SCALE_WIDTH-1:0] tgt_shift;
  logic signed [POS_WIDTH-1:0]             tgt_new;
  logic signed [POS_WIDTH-1:0]             pos;
  logic signed [POS_WIDTH:0]               diff;
  logic signed [POS_WIDTH-1:0]             err;
  logic signed [POS_WIDTH:0]               err_ext;
  logic signed [POS_WIDTH:0]               db_pos;
  logic signed [POS_WIDTH:0]               db_neg;
  logic                                    in_band;
  logic signed [INTEGRAL_WIDTH:0]          sum_wide;
  logic signed [INTEGRAL_WIDTH-1:0]        sum_sat;
  logic signed [POS_WIDTH:0]               deriv;
  logic signed [PROD_P_WIDTH-1:0]          prod_p;
  logic signed [PROD_D_WIDTH-1:0]          prod_d;
  logic signed [PROD_I_WIDTH-1:0]          prod_i;
  logic signed [SUM_WIDTH-1:0]             total;
  logic signed [SUM_WIDTH-1:0]             scaled;
  logic signed [SUM_WIDTH-1:0]             lim_pos;
  logic signed [SUM_WIDTH-1:0]             lim_neg;
  logic signed [SUM_WIDTH-1:0]             clamped;
  logic [TICKS_WIDTH-1:0]                  cnt_inc;
  logic                                    settle_done;

  always_comb begin
    tgt_prod  = target_distance_i * SCALE_S;
    tgt_shift = tgt_prod >>> 16;
    tgt_new   = POS_WIDTH'(tgt_shift);

    pos = (encoder_raw_i == POS_MIN) ? POS_MAX : -encoder_raw_i;
    diff = (POS_WIDTH+1)'(pos) - (POS_WIDTH+1)'(target_q);
    if (diff[POS_WIDTH] != diff[POS_WIDTH-1]) begin
      err = diff[POS_WIDTH] ? POS_MIN : POS_MAX;
    end else begin
      err = diff[POS_WIDTH-1:0];
    end

    err_ext = (POS_WIDTH+1)'(err);
    db_pos  = $signed({{(POS_WIDTH+1-DBAND_WIDTH){1'b0}}, cfg_i.deadband});
    db_neg  = -db_pos;
    in_band = (err_ext < db_pos) && (err_ext > db_neg);

    sum_wide = (INTEGRAL_WIDTH+1)'(err_sum_q) + (INTEGRAL_WIDTH+1)'(err);
    if (sum_wide[INTEGRAL_WIDTH] != sum_wide[INTEGRAL_WIDTH-1]) begin
      sum_sat = sum_wide[INTEGRAL_WIDTH] ? INT_MIN : INT_MAX;
    end else begin
      sum_sat = sum_wide[INTEGRAL_WIDTH-1:0];
    end

    deriv  = err_ext - (POS_WIDTH+1)'(prev_err_q);
    prod_p = cfg_i.gain_p * err;
    prod_d = cfg_i.gain_d * deriv;
    prod_i = cfg_i.gain_i * sum_sat;
    total  = SUM_WIDTH'(prod_p) + SUM_WIDTH'(prod_d) + SUM_WIDTH'(prod_i);
    scaled = total >>> 8;

    lim_pos = $signed({{(SUM_WIDTH-LIMIT_WIDTH){1'b0}}, cfg_i.drive_limit});
    lim_neg = -lim_pos;
    if (scaled > lim_pos) begin
      clamped = lim_pos;
    end else if (scaled < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = scaled;
    end

    cnt_inc     = (settle_cnt_q == {TICKS_WIDTH{1'b1}}) ? settle_cnt_q
                                                         : settle_cnt_q + 1'b1;
    settle_done = (cnt_inc >= cfg_i.settle_ticks);
  end

  always_comb begin
    target_d     = target_q;
    prev_err_d   = prev_err_q;
    err_sum_d    = err_sum_q;
    settle_cnt_d = settle_cnt_q;
    finished_d   = finished_q;
    res_o.motor_command = CMD_HOLD;
    res_o.drive_value   = '0;
    res_o.reset_sensors = 1'b0;

    if (opcode_i == OP_SET) begin
      target_d   = tgt_new;
      finished_d = 1'b0;
    end else if (!in_band) begin
      settle_cnt_d = '0;
      finished_d   = 1'b0;
      err_sum_d    = sum_sat;
      prev_err_d   = err;
      res_o.motor_command = CMD_DRIVE;
      res_o.drive_value   = DRIVE_WIDTH'(clamped);
    end else if (settle_done) begin
      settle_cnt_d = '0;
      finished_d   = 1'b1;
      target_d     = '0;
      prev_err_d   = '0;
      res_o.motor_command = CMD_STOP;
      res_o.reset_sensors = 1'b1;
    end else begin
      settle_cnt_d = cnt_inc;
    end

    res_o.move_finished = finished_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= '0;
      prev_err_q   <= '0;
      err_sum_q    <= '0;
      settle_cnt_q <= '0;
      finished_q   <= 1'b1;
    end else if (step_i) begin
      target_q     <= target_d;
      prev_err_q   <= prev_err_d;
      err_sum_q    <= err_sum_d;
      settle_cnt_q <= settle_cnt_d;
      finished_q   <= finished_d;
    end
  end

endmodule

>>> rtl/pid_pls_checker.sv
// Port-level assertions for the position PID loop and their bind statement.
module pid_pls_checker
  import pid_pls_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    motor_command_o,
  input logic signed [DRIVE_WIDTH-1:0] drive_value_o,
  input logic                          move_finished_o,
  input logic                          reset_sensors_o
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(motor_command_o)
      && $stable(drive_value_o) && $stable(move_finished_o)
      && $stable(reset_sensors_o))
    else $error("stalled result changed");

  // The drive value is zero unless the command is drive.
  a_drive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motor_command_o != CMD_DRIVE |-> drive_value_o == '0)
    else $error("drive value set without drive command");

  // A sensor reset comes only with a stop that finishes the move, and every stop has one.
  a_stop_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reset_sensors_o == (motor_command_o == CMD_STOP))
      && (!reset_sensors_o || move_finished_o))
    else $error("stop and sensor reset disagree");

  // A driving tick always leaves the move unfinished.
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motor_command_o == CMD_DRIVE |-> !move_finished_o)
    else $error("finished while driving");

endmodule

bind pid_position_loop_with_settle pid_pls_checker u_pid_pls_checker (.*);

>>> sim/tb_pid_position_loop_with_settle.sv
`timescale 1ns / 1ps
// Self-checking testbench for the position PID loop with settle detection.
module tb_pid_position_loop_with_settle;
  import pid_pls_pkg::*;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_B = 3'd7;
  localparam longint ACC_MAX = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint PROD_CAP = longint'(1) <<< 61;
  localparam longint POS_MAX = 2147483647;
  localparam longint POS_MIN = -POS_MAX - 1;

  typedef struct {
    logic                 op;
    logic [POS_WIDTH-1:0] enc;
    logic [POS_WIDTH-1:0] distance;
    bit                   typed;
    res_t                 want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = OP_TICK;
  logic [POS_WIDTH-1:0] encoder_raw = '0;
  logic [POS_WIDTH-1:0] target_distance = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] motor_command;
  logic signed [DRIVE_WIDTH-1:0] drive_value;
  logic move_finished;
  logic reset_sensors;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  // Predictor copy of the registers and the loop state.
  logic signed [GAIN_WIDTH-1:0] kp = RST_GAIN_P;
  logic signed [GAIN_WIDTH-1:0] ki = RST_GAIN_I;
  logic signed [GAIN_WIDTH-1:0] kd = RST_GAIN_D;
  logic [DBAND_WIDTH-1:0] band = RST_DEADBAND;
  logic [TICKS_WIDTH-1:0] settle_need = RST_SETTLE_TICKS;
  logic [LIMIT_WIDTH-1:0] lim_cfg = RST_DRIVE_LIMIT;
  longint tgt_pos = 0;
  longint last_err = 0;
  longint err_acc = 0;
  int unsigned settle_cnt = 0;
  bit done_flag = 1'b1;

  res_t drive_results_q[$];
  stim_row_t stim_table[$];

  int unsigned cycles = 0;
  int unsigned n_bad = 0;
  int unsigned n_sets = 0;
  int unsigned n_ticks = 0;
  int unsigned n_drive = 0;
  int unsigned n_stop = 0;
  int unsigned n_hold = 0;
  int unsigned n_settings = 0;
  int unsigned burst_left = 0;
  int unsigned hit_pct = 75;
  bit gaps_on = 1'b1;
  bit valid_low = 1'b1;
  int unsigned hold_reqs = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned seg_left = 0;
  int unsigned stall_pct = 0;

  pid_position_loop_with_settle dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .opcode_i          (opcode),
    .encoder_raw_i     (encoder_raw),
    .target_distance_i (target_distance),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .motor_command_o   (motor_command),
    .drive_value_o     (drive_value),
    .move_finished_o   (move_finished),
    .reset_sensors_o   (reset_sensors),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint clip32(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic res_t pid_loop_step(logic op, logic signed [POS_WIDTH-1:0] enc,
                                         logic signed [POS_WIDTH-1:0] distance);
    res_t r;
    longint pos, err, deriv, p_i, total, drv, lim;
    r = '0;
    r.motor_command = CMD_HOLD;
    if (op == OP_SET) begin
      tgt_pos = (longint'(distance) * TARGET_SCALE) >>> 16;
      done_flag = 1'b0;
    end else begin
      pos = clip32(-longint'(enc));
      err = clip32(pos - tgt_pos);
      if (!(err < longint'(band) && err > -longint'(band))) begin
        deriv = err - last_err;
        settle_cnt = 0;
        done_flag = 1'b0;
        if (err > 0 && err_acc > ACC_MAX - err) err_acc = ACC_MAX;
        else if (err < 0 && err_acc < ACC_MIN - err) err_acc = ACC_MIN;
        else err_acc += err;
        p_i = err_acc * longint'(ki);
        if (p_i > PROD_CAP) p_i = PROD_CAP;
        else if (p_i < -PROD_CAP) p_i = -PROD_CAP;
        total = longint'(kp) * err + longint'(kd) * deriv + p_i;
        drv = total >>> 8;
        lim = longint'(lim_cfg);
        if (drv > lim) drv = lim;
        if (drv < -lim) drv = -lim;
        r.motor_command = CMD_DRIVE;
        r.drive_value = drv[DRIVE_WIDTH-1:0];
        last_err = err;
      end else begin
        if (settle_cnt < 15) settle_cnt++;
        if (settle_cnt >= settle_need) begin
          settle_cnt = 0;
          done_flag = 1'b1;
          tgt_pos = 0;
          last_err = 0;
          r.motor_command = CMD_STOP;
          r.reset_sensors = 1'b1;
        end
      end
    end
    r.move_finished = done_flag;
    return r;
  endfunction

  // Result monitor and receiver stall pattern.
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.motor_command = motor_command;
      got.drive_value = drive_value;
      got.move_finished = move_finished;
      got.reset_sensors = reset_sensors;
      case (got.motor_command)
        CMD_DRIVE: n_drive++;
        CMD_STOP: n_stop++;
        default: n_hold++;
      endcase
      if (drive_results_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("%0t: unexpected result, cmd %0d drive %0d", $time,
                                  got.motor_command, got.drive_value);
      end else begin
        want = drive_results_q.pop_front();
        if (got.motor_command !== want.motor_command || got.drive_value !== want.drive_value ||
            got.move_finished !== want.move_finished ||
            got.reset_sensors !== want.reset_sensors) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: expected cmd %0d drive %0d fin %0b rst %0b, got %0d %0d %0b %0b",
                     $time, want.motor_command, want.drive_value, want.move_finished,
                     want.reset_sensors, got.motor_command, got.drive_value,
                     got.move_finished, got.reset_sensors);
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_reqs != hold_done) begin
      hold_done++;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 120);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      seg_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic add_row(logic op, logic [POS_WIDTH-1:0] enc,
                         logic [POS_WIDTH-1:0] distance,
                         bit typed, logic [1:0] cmd, int drv, bit fin, bit rst);
    stim_row_t r;
    r.op = op;
    r.enc = enc;
    r.distance = distance;
    r.typed = typed;
    r.want.motor_command = cmd;
    r.want.drive_value = drv[DRIVE_WIDTH-1:0];
    r.want.move_finished = fin;
    r.want.reset_sensors = rst;
    stim_table.push_back(r);
  endtask

  task automatic send_item(logic op, logic [POS_WIDTH-1:0] enc,
                           logic [POS_WIDTH-1:0] distance,
                           bit typed, res_t want);
    res_t pred;
    int unsigned gap;
    opcode <= op;
    encoder_raw <= enc;
    target_distance <= distance;
    in_valid <= 1'b1;
    valid_low = 1'b0;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = pid_loop_step(op, enc, distance);
    drive_results_q.push_back(typed ? want : pred);
    if (op == OP_SET) n_sets++;
    else n_ticks++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 23);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gaps_on && $urandom_range(0, 9) == 0) gap = $urandom_range(7, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_low = 1'b1;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    if (!valid_low) in_valid <= 1'b0;
    valid_low = 1'b1;
    while (drive_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_GAIN_P: kp = data[GAIN_WIDTH-1:0];
      CFG_GAIN_I: ki = data[GAIN_WIDTH-1:0];
      CFG_GAIN_D: kd = data[GAIN_WIDTH-1:0];
      CFG_DEADBAND: band = data[DBAND_WIDTH-1:0];
      CFG_SETTLE_TICKS: settle_need = data[TICKS_WIDTH-1:0];
      CFG_DRIVE_LIMIT: lim_cfg = data[LIMIT_WIDTH-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                               logic [15:0] b, logic [3:0] t, logic [22:0] l);
    cfg_write(CFG_GAIN_P, 23'(p));
    cfg_write(CFG_GAIN_I, 23'(i));
    cfg_write(CFG_GAIN_D, 23'(d));
    cfg_write(CFG_DEADBAND, 23'(b));
    cfg_write(CFG_SETTLE_TICKS, 23'(t));
    cfg_write(CFG_DRIVE_LIMIT, l);
    n_settings++;
  endtask

  // Mostly ticks close to the current target, so moves settle, plus sets and noise.
  task automatic pick_item(output logic op, output logic [POS_WIDTH-1:0] enc,
                           output logic [POS_WIDTH-1:0] distance);
    int unsigned roll;
    longint off, b, v;
    roll = $urandom_range(0, 99);
    b = longint'(band);
    op = OP_TICK;
    enc = $urandom;
    distance = $urandom;
    if (roll < 5) begin
      op = OP_SET;
      if ($urandom_range(0, 2) != 0)
        distance = 32'($urandom_range(0, 2097151)) - 32'd1048576;
    end else if (roll >= 11) begin
      if (b > 0 && $urandom_range(0, 99) < hit_pct) begin
        off = longint'($urandom_range(0, 2 * b - 2)) - (b - 1);
      end else begin
        off = b + longint'($urandom_range(0, $urandom_range(0, 1) ? 4000 : 1000000));
        if ($urandom_range(0, 1)) off = -off;
      end
      v = -(tgt_pos + off);
      enc = v[POS_WIDTH-1:0];
    end
  endtask

  task automatic run_random(int unsigned n, bit gaps);
    logic op;
    logic [POS_WIDTH-1:0] enc, distance;
    gaps_on = gaps;
    hit_pct = $urandom_range(60, 95);
    repeat (n) begin
      pick_item(op, enc, distance);
      send_item(op, enc, distance, 1'b0, '0);
    end
    wait_idle();
  endtask

  initial begin
    //       op       encoder        distance      typed cmd        drive  fin rst
    add_row(OP_TICK, 32'h0000_0000, 32'h0000_0000, 1, CMD_HOLD,  0,       1,  0);
    add_row(OP_SET,  32'h0000_0000, 32'h0000_0000, 1, CMD_HOLD,  0,       0,  0);
    add_row(OP_TICK, 32'h8000_0000, 32'h0000_0000, 1, CMD_DRIVE, 786432,  0,  0);
    add_row(OP_TICK, 32'h7FFF_FFFF, 32'h0000_0000, 1, CMD_DRIVE, -786432, 0,  0);
    add_row(OP_TICK, 32'hFFFF_FD71, 32'h0000_0000, 1, CMD_DRIVE, 1310,    0,  0);
    add_row(OP_TICK, 32'h0000_028F, 32'h0000_0000, 1, CMD_DRIVE, -1310,   0,  0);
    add_row(OP_TICK, 32'hFFFF_FD72, 32'h0000_0000, 1, CMD_HOLD,  0,       0,  0);
    add_row(OP_TICK, 32'h0000_028E, 32'h0000_0000, 1, CMD_HOLD,  0,       0,  0);
    add_row(OP_TICK, 32'h0000_0000, 32'h0000_0000, 1, CMD_HOLD,  0,       0,  0);
    add_row(OP_TICK, 32'h0000_0000, 32'h0000_0000, 1, CMD_HOLD,  0,       0,  0);
    add_row(OP_TICK, 32'h0000_0000, 32'h0000_0000, 1, CMD_STOP,  0,       1,  1);
    add_row(OP_TICK, 32'h0000_0000, 32'h0000_0000, 1, CMD_HOLD,  0,       1,  0);
    add_row(OP_SET,  32'h0000_0000, 32'h7FFF_FFFF, 1, CMD_HOLD,  0,       0,  0);
    add_row(OP_TICK, 32'hF12F_0001, 32'h0000_0000, 0, CMD_HOLD,  0,       0,  0);
    add_row(OP_SET,  32'h0000_0000, 32'h8000_0000, 1, CMD_HOLD,  0,       0,  0);
    add_row(OP_TICK, 32'h8000_0000, 32'h0000_0000, 1, CMD_DRIVE, 786432,  0,  0);
    add_row(OP_TICK, 32'h7FFF_FFFF, 32'h0000_0000, 1, CMD_DRIVE, -786432, 0,  0);
    add_row(OP_TICK, 32'h0ED1_0000, 32'h0000_0000, 0, CMD_HOLD,  0,       0,  0);
    add_row(OP_SET,  32'h0000_0000, 32'h0000_0001, 1, CMD_HOLD,  0,       0,  0);
    add_row(OP_SET,  32'h0000_0000, 32'hFFFF_FFFF, 1, CMD_HOLD,  0,       0,  0);
    add_row(OP_TICK, 32'h0000_0001, 32'h0000_0000, 0, CMD_HOLD,  0,       0,  0);
    add_row(OP_TICK, 32'h5555_5555, 32'h0000_0000, 0, CMD_HOLD,  0,       0,  0);
    add_row(OP_TICK, 32'hAAAA_AAAA, 32'h0000_0000, 0, CMD_HOLD,  0,       0,  0);
    add_row(OP_SET,  32'h0000_0000, 32'h1234_5678, 0, CMD_HOLD,  0,       0,  0);
    add_row(OP_TICK, 32'hEDCB_A987, 32'h0000_0000, 0, CMD_HOLD,  0,       0,  0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[k])
      send_item(stim_table[k].op, stim_table[k].enc, stim_table[k].distance,
                stim_table[k].typed, stim_table[k].want);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_setting(16'd512, 16'd4, 16'd128, 16'd655, 4'd3, RST_DRIVE_LIMIT);
        1: begin
          apply_setting(16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 4'd15, 23'h7F_FFFF);
          hold_reqs++;
        end
        2: apply_setting(16'h8000, 16'h7FFF, 16'h7FFF, 16'd0, 4'd1, 23'd0);
        3: begin
          apply_setting(16'd700, 16'd0, 16'hFED4, 16'd1000, 4'd0, 23'h7F_FFFF);
          cfg_write(CFG_SPARE_A, 23'h7F_FFFF);
          cfg_write(CFG_SPARE_B, 23'h2A_AAAA);
        end
        default:
          apply_setting(16'($urandom_range(0, 4095) - 2048), 16'($urandom_range(0, 63) - 32),
                        16'($urandom_range(0, 1023) - 512), 16'($urandom_range(0, 3000)),
                        4'($urandom_range(1, 8)),
                        $urandom_range(0, 1) ? 23'($urandom) : RST_DRIVE_LIMIT);
      endcase
      run_random(125, p != 5);
    end

    apply_setting(16'd300, 16'h8000, 16'd50, 16'd800, 4'd2, RST_DRIVE_LIMIT);
    run_random(100, 1'b1);

    $display("Covered %0d transactions (%0d set-target, %0d ticks) under %0d register settings.",
             n_sets + n_ticks, n_sets, n_ticks, n_settings);
    $display("Results: %0d drive, %0d stop, %0d hold; %0d bad.", n_drive, n_stop, n_hold, n_bad);
    if (n_bad == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
